@@ rtl/core/bmhq_pkg.sv @@
// Shared types and defaults for the binary min-heap queue.
// No dependencies; imported by bmhq_cell and binary_min_heap_queue.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int HEAP_CAPACITY    = 256;
  localparam int HEAP_KEY_BITS    = 32;
  localparam int HEAP_HANDLE_BITS = 9;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_PEEK   = 2'd2
  } mode_e;

  // work carried down the level chain
  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_SIFT = 1'b1
  } tok_op_e;

  typedef struct packed {
    logic    vld;
    tok_op_e op;
    logic    shift;  // push: entry already placed above, displace every node below
  } tok_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FREQ,
    ST_FDATA,
    ST_WALK
  } state_e;

endpackage

@@ rtl/core/bmhq_cell.sv @@
// One heap level below the root: sibling-pair storage plus push / sift step logic.
// Depends on bmhq_pkg; chained by binary_min_heap_queue.
`timescale 1ns / 1ps

module bmhq_cell import bmhq_pkg::*; #(
  parameter int LEVEL       = 1,
  parameter int CAPACITY    = HEAP_CAPACITY,
  parameter int KEY_BITS    = HEAP_KEY_BITS,
  parameter int HANDLE_BITS = HEAP_HANDLE_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // token from the level above
  input  tok_ctl_t                               tok_i,
  input  logic [KEY_BITS+HANDLE_BITS-1:0]        tok_ent_i,
  input  logic [$clog2(CAPACITY+1)-1:0]          tok_off_i,
  // token to the level below
  output tok_ctl_t                               tok_o,
  output logic [KEY_BITS+HANDLE_BITS-1:0]        tok_ent_o,
  output logic [$clog2(CAPACITY+1)-1:0]          tok_off_o,
  // write into the level above
  output logic                                   up_vld_o,
  output logic [$clog2(CAPACITY+1)-1:0]          up_off_o,
  output logic [KEY_BITS+HANDLE_BITS-1:0]        up_ent_o,
  // write from the level below
  input  logic                                   dn_vld_i,
  input  logic [$clog2(CAPACITY+1)-1:0]          dn_off_i,
  input  logic [KEY_BITS+HANDLE_BITS-1:0]        dn_ent_i,
  // shared operation context
  input  logic [$clog2(CAPACITY+1)-1:0]          path_n_i,
  input  logic [$clog2($clog2(CAPACITY+1))-1:0]  path_d_i,
  input  logic [$clog2(CAPACITY+1)-1:0]          cnt_i,
  // last-entry fetch
  input  logic                                   fetch_i,
  input  logic [$clog2(CAPACITY+1)-1:0]          fetch_off_i,
  output logic [KEY_BITS+HANDLE_BITS-1:0]        fd_ent_o,
  output logic                                   done_o
);

  localparam int EW        = KEY_BITS + HANDLE_BITS;
  localparam int CW        = $clog2(CAPACITY + 1);
  localparam int OW        = CW;
  localparam int LVW       = $clog2(CW);
  localparam int IW        = CW + 1;
  localparam int LVL_ENT   = CAPACITY - ((2 ** LEVEL) - 1);
  localparam int ROWS_FULL = 2 ** (LEVEL - 1);
  localparam int ROWS_TRIM = (LVL_ENT + 1) / 2;
  localparam int ROWS      = (ROWS_TRIM < ROWS_FULL) ? ROWS_TRIM : ROWS_FULL;
  localparam int AW        = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [EW-1:0] mem_lo [ROWS];
  logic [EW-1:0] mem_hi [ROWS];
  logic [EW-1:0] rd_lo_q, rd_hi_q;
  logic          fd_half_q;

  logic          st_vld_q;
  tok_op_e       st_op_q;
  logic          st_shift_q;
  logic [EW-1:0] st_ent_q;
  logic [OW-1:0] st_off_q;

  tok_ctl_t      tok_d, tok_q;
  logic [EW-1:0] tok_ent_d, tok_ent_q;
  logic [OW-1:0] tok_off_d, tok_off_q;
  logic          done_d, done_q;

  logic          own_wr;
  logic [OW-1:0] own_off;
  logic [EW-1:0] own_ent;
  logic          wr_en;
  logic [OW-1:0] wr_off;
  logic [EW-1:0] wr_ent;
  logic          rd_en;
  logic [AW-1:0] rd_row;

  logic [EW-1:0]       cur, pk;
  logic                pick_hi, right_ok, at_target;
  logic [IW-1:0]       left_idx, right_idx, hole_idx;
  logic [IW:0]         cidx;
  logic [CW-1:0]       nsh;
  logic [KEY_BITS-1:0] st_key;

  assign st_key    = st_ent_q[EW-1:HANDLE_BITS];
  assign at_target = (path_d_i == LVW'(LEVEL));
  assign nsh       = path_n_i >> (path_d_i - LVW'(LEVEL) - LVW'(1));

  assign cur       = st_off_q[0] ? rd_hi_q : rd_lo_q;
  assign left_idx  = IW'((2 ** LEVEL) - 1) + {st_off_q, 1'b0};
  assign right_idx = left_idx + IW'(1);
  assign right_ok  = right_idx < {1'b0, cnt_i};
  assign pick_hi   = right_ok && (rd_hi_q[EW-1:HANDLE_BITS] < rd_lo_q[EW-1:HANDLE_BITS]);
  assign pk        = pick_hi ? rd_hi_q : rd_lo_q;
  assign hole_idx  = left_idx + IW'(pick_hi);
  assign cidx      = {hole_idx, 1'b1};

  always_comb begin
    tok_d     = '{vld: 1'b0, op: st_op_q, shift: 1'b1};
    tok_ent_d = st_ent_q;
    tok_off_d = '0;
    own_wr    = 1'b0;
    own_off   = st_off_q;
    own_ent   = st_ent_q;
    up_vld_o  = 1'b0;
    up_off_o  = st_off_q;
    up_ent_o  = st_ent_q;
    done_d    = 1'b0;
    if (st_vld_q) begin
      case (st_op_q)
        OP_PUSH: begin
          if (at_target) begin
            own_wr = 1'b1;
            done_d = 1'b1;
          end else begin
            tok_d.vld = 1'b1;
            tok_off_d = {st_off_q[OW-2:0], nsh[0]};
            if (st_shift_q || (st_key < cur[EW-1:HANDLE_BITS])) begin
              own_wr    = 1'b1;
              tok_ent_d = cur;
            end else begin
              tok_d.shift = 1'b0;
            end
          end
        end
        OP_SIFT: begin
          up_vld_o = 1'b1;
          if (pk[EW-1:HANDLE_BITS] < st_key) begin
            up_ent_o = pk;
            if (cidx < {2'b00, cnt_i}) begin
              tok_d.vld = 1'b1;
              tok_off_d = {st_off_q[OW-2:0], pick_hi};
            end else begin
              own_wr  = 1'b1;
              own_off = {st_off_q[OW-2:0], pick_hi};
              done_d  = 1'b1;
            end
          end else begin
            done_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign wr_en  = own_wr | dn_vld_i;
  assign wr_off = own_wr ? own_off : dn_off_i;
  assign wr_ent = own_wr ? own_ent : dn_ent_i;

  assign rd_en  = fetch_i | tok_i.vld;

  always_comb begin
    if (fetch_i) begin
      rd_row = fetch_off_i[AW:1];
    end else if (tok_i.op == OP_PUSH) begin
      rd_row = tok_off_i[AW:1];
    end else begin
      rd_row = tok_off_i[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_off[0]) begin
      mem_lo[wr_off[AW:1]] <= wr_ent;
    end
    if (wr_en && wr_off[0]) begin
      mem_hi[wr_off[AW:1]] <= wr_ent;
    end
    if (rd_en) begin
      rd_lo_q <= mem_lo[rd_row];
      rd_hi_q <= mem_hi[rd_row];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch_i) begin
      fd_half_q <= fetch_off_i[0];
    end
    if (tok_i.vld) begin
      st_op_q    <= tok_i.op;
      st_shift_q <= tok_i.shift;
      st_ent_q   <= tok_ent_i;
      st_off_q   <= tok_off_i;
    end
    tok_ent_q <= tok_ent_d;
    tok_off_q <= tok_off_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
      tok_q    <= '{vld: 1'b0, op: OP_PUSH, shift: 1'b0};
      done_q   <= 1'b0;
    end else begin
      st_vld_q <= tok_i.vld;
      tok_q    <= tok_d;
      done_q   <= done_d;
    end
  end

  assign tok_o     = tok_q;
  assign tok_ent_o = tok_ent_q;
  assign tok_off_o = tok_off_q;
  assign fd_ent_o  = fd_half_q ? rd_hi_q : rd_lo_q;
  assign done_o    = done_q;

endmodule

@@ rtl/core/binary_min_heap_queue.sv @@
// Top level of the binary min-heap queue: root register, sequencer, chain of level cells.
// Depends on bmhq_pkg and bmhq_cell.
`timescale 1ns / 1ps

// Min-heap of CAPACITY (key, handle) entries held as a chain of level cells, one per
// heap level below a root register; each cell stores its level as sibling pairs in two
// RAMs. A request is taken when start is high and busy is low, and gives one result
// beat, done_o high for exactly one cycle; the receiver cannot stall it. Peek, an empty
// pop, a full insert, an insert into an empty heap and a pop of the only entry finish in
// the accept cycle: the beat follows next cycle and another request may be issued at
// once. A pop that leaves one entry passes through ST_FREQ and ST_FDATA before it
// returns to idle. An insert that lands at heap level D >= 1 (D = floor(log2(count+1)),
// count before the insert) walks a push token down the cells to level D; a pop that
// leaves two or more entries fetches the last entry, then sifts it down from the root.
// At each level a registered RAM read of a sibling pair is followed by a compare and
// write step. Storage has no reset; only entries below the count are ever used.

module binary_min_heap_queue import bmhq_pkg::*; #(
  parameter int CAPACITY    = HEAP_CAPACITY,
  parameter int KEY_BITS    = HEAP_KEY_BITS,
  parameter int HANDLE_BITS = HEAP_HANDLE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    mode_i,
  input  logic [KEY_BITS-1:0]           key_i,
  input  logic [HANDLE_BITS-1:0]        handle_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [KEY_BITS-1:0]           out_key_o,
  output logic [HANDLE_BITS-1:0]        out_handle_o,
  output logic                          overflow_o,
  output logic [$clog2(CAPACITY+1)-1:0] occupancy_o
);

  localparam int EW     = KEY_BITS + HANDLE_BITS;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = CW;
  localparam int LVW    = $clog2(LEVELS);

  function automatic logic [LVW-1:0] msb_pos(input logic [CW-1:0] v);
    logic [LVW-1:0] r;
    r = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) r = LVW'(i);
    end
    return r;
  endfunction

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q;
  logic [EW-1:0]  root_q;
  logic [CW-1:0]  nval_q;
  logic [LVW-1:0] lvl_q;
  tok_ctl_t       t0_q;
  logic [EW-1:0]  t0_ent_q;
  logic [CW-1:0]  t0_off_q;
  logic           done_q, done_d;
  logic           res_found_q, res_ovf_q;
  logic [EW-1:0]  res_ent_q;

  tok_ctl_t       tok_ctl [LEVELS];
  logic [EW-1:0]  tok_ent [LEVELS];
  logic [CW-1:0]  tok_off [LEVELS];
  logic           up_vld  [1:LEVELS];
  logic [CW-1:0]  up_off  [1:LEVELS];
  logic [EW-1:0]  up_ent  [1:LEVELS];
  logic [EW-1:0]  fd_ent  [LEVELS];
  logic [LEVELS-1:0] cell_done;

  logic           acc, full, empty, x_lt_root, ibit, done_any, fetch_vld;
  logic [EW-1:0]  x, fd_sel;
  logic [CW-1:0]  enc_n, ins_sh, fetch_off;
  logic [LVW-1:0] enc_d;

  assign x         = {key_i, handle_i};
  assign acc       = start && (state_q == ST_IDLE);
  assign full      = (cnt_q == CW'(CAPACITY));
  assign empty     = (cnt_q == '0);
  assign x_lt_root = key_i < root_q[EW-1:HANDLE_BITS];
  assign enc_n     = (mode_e'(mode_i) == MODE_INSERT) ? (cnt_q + CW'(1)) : cnt_q;
  assign enc_d     = msb_pos(enc_n);
  assign ins_sh    = enc_n >> (enc_d - LVW'(1));
  assign ibit      = ins_sh[0];
  assign done_any  = |cell_done;
  assign fetch_vld = (state_q == ST_FREQ);
  assign fetch_off = nval_q & ~(CW'(1) << lvl_q);
  assign fd_sel    = fd_ent[lvl_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (mode_e'(mode_i))
            MODE_INSERT: if (!full && !empty) state_d = ST_WALK;
            MODE_POP:    if (cnt_q > CW'(1)) state_d = ST_FREQ;
            default: ;
          endcase
        end
      end
      ST_FREQ:  state_d = ST_FDATA;
      ST_FDATA: state_d = (cnt_q >= CW'(2)) ? ST_WALK : ST_IDLE;
      ST_WALK:  if (done_any) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    done_d = (state_d == ST_IDLE) && (acc || (state_q != ST_IDLE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      t0_q    <= '{vld: 1'b0, op: OP_PUSH, shift: 1'b0};
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (acc) begin
        case (mode_e'(mode_i))
          MODE_INSERT: if (!full) cnt_q <= cnt_q + CW'(1);
          MODE_POP:    if (!empty) cnt_q <= cnt_q - CW'(1);
          default: ;
        endcase
      end
      if (acc && (mode_e'(mode_i) == MODE_INSERT) && !full && !empty) begin
        t0_q <= '{vld: 1'b1, op: OP_PUSH, shift: x_lt_root};
      end else if ((state_q == ST_FDATA) && (cnt_q >= CW'(2))) begin
        t0_q <= '{vld: 1'b1, op: OP_SIFT, shift: 1'b0};
      end else begin
        t0_q.vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_vld[1]) begin
      root_q <= up_ent[1];
    end
    if (acc) begin
      nval_q <= enc_n;
      lvl_q  <= enc_d;
      case (mode_e'(mode_i))
        MODE_INSERT: begin
          res_found_q <= 1'b1;
          res_ovf_q   <= full;
          if (full) begin
            res_ent_q <= root_q;
          end else if (empty || x_lt_root) begin
            root_q    <= x;
            res_ent_q <= x;
          end else begin
            res_ent_q <= root_q;
          end
          t0_ent_q <= x_lt_root ? root_q : x;
          t0_off_q <= CW'(ibit);
        end
        default: begin
          res_found_q <= !empty;
          res_ovf_q   <= 1'b0;
          res_ent_q   <= empty ? '0 : root_q;
        end
      endcase
    end
    if (state_q == ST_FDATA) begin
      if (cnt_q >= CW'(2)) begin
        t0_ent_q <= fd_sel;
        t0_off_q <= '0;
      end else begin
        root_q <= fd_sel;
      end
    end
  end

  assign tok_ctl[0]     = t0_q;
  assign tok_ent[0]     = t0_ent_q;
  assign tok_off[0]     = t0_off_q;
  assign fd_ent[0]      = root_q;
  assign cell_done[0]   = 1'b0;
  assign up_vld[LEVELS] = 1'b0;
  assign up_off[LEVELS] = '0;
  assign up_ent[LEVELS] = '0;

  for (genvar g = 1; g < LEVELS; g++) begin : g_lvl
    bmhq_cell #(
      .LEVEL       (g),
      .CAPACITY    (CAPACITY),
      .KEY_BITS    (KEY_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tok_i       (tok_ctl[g-1]),
      .tok_ent_i   (tok_ent[g-1]),
      .tok_off_i   (tok_off[g-1]),
      .tok_o       (tok_ctl[g]),
      .tok_ent_o   (tok_ent[g]),
      .tok_off_o   (tok_off[g]),
      .up_vld_o    (up_vld[g]),
      .up_off_o    (up_off[g]),
      .up_ent_o    (up_ent[g]),
      .dn_vld_i    (up_vld[g+1]),
      .dn_off_i    (up_off[g+1]),
      .dn_ent_i    (up_ent[g+1]),
      .path_n_i    (nval_q),
      .path_d_i    (lvl_q),
      .cnt_i       (cnt_q),
      .fetch_i     (fetch_vld && (lvl_q == LVW'(g))),
      .fetch_off_i (fetch_off),
      .fd_ent_o    (fd_ent[g]),
      .done_o      (cell_done[g])
    );
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign found_o      = res_found_q;
  assign out_key_o    = res_ent_q[EW-1:HANDLE_BITS];
  assign out_handle_o = res_ent_q[HANDLE_BITS-1:0];
  assign overflow_o   = res_ovf_q;
  assign occupancy_o  = cnt_q;

endmodule

@@ tb/sv/binary_min_heap_queue_tb.sv @@
// Self-checking bench for binary_min_heap_queue: a table of directed requests, then
// random fill/drain/mixed phases, each beat checked against table values or an in-bench heap model.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL.
`timescale 1ns / 1ps

module binary_min_heap_queue_tb import bmhq_pkg::*;;

  localparam int KB          = HEAP_KEY_BITS;
  localparam int HB          = HEAP_HANDLE_BITS;
  localparam int OCC_BITS    = $clog2(HEAP_CAPACITY + 1);
  localparam int ITEMS       = 1200;
  localparam int CALM_TAIL   = 150;
  localparam int WDOG_LIMIT  = 1000;
  localparam int SETTLE_CYC  = 30;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic                found;
    logic [KB-1:0]       key;
    logic [HB-1:0]       hnd;
    logic                ovf;
    logic [OCC_BITS-1:0] occ;
  } heap_reply_t;

  typedef struct {
    logic [1:0]  mode;
    logic [KB-1:0] key;
    logic [HB-1:0] hnd;
    bit          typed;
    heap_reply_t want;
  } req_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          mode_i;
  logic [KB-1:0]       key_i;
  logic [HB-1:0]       handle_i;
  logic                done_o;
  logic                found_o;
  logic [KB-1:0]       out_key_o;
  logic [HB-1:0]       out_handle_o;
  logic                overflow_o;
  logic [OCC_BITS-1:0] occupancy_o;

  binary_min_heap_queue u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .key_i        (key_i),
    .handle_i     (handle_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .out_key_o    (out_key_o),
    .out_handle_o (out_handle_o),
    .overflow_o   (overflow_o),
    .occupancy_o  (occupancy_o)
  );

  logic [KB-1:0] heap_key [HEAP_CAPACITY];
  logic [HB-1:0] heap_hnd [HEAP_CAPACITY];
  int            heap_cnt = 0;

  heap_reply_t heap_reply_q[$];
  req_row_t    req_tab[$];
  int          err_cnt      = 0;
  int          sent         = 0;
  int          idle_pct     = 0;
  int          stall_cycles = 0;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void heap_swap(int a, int b);
    logic [KB-1:0] tk;
    logic [HB-1:0] th;
    tk = heap_key[a];
    th = heap_hnd[a];
    heap_key[a] = heap_key[b];
    heap_hnd[a] = heap_hnd[b];
    heap_key[b] = tk;
    heap_hnd[b] = th;
  endfunction

  function automatic heap_reply_t heap_apply(logic [1:0] m, logic [KB-1:0] k, logic [HB-1:0] h);
    heap_reply_t r;
    int pos;
    int up;
    int lt;
    int pick;
    r = '{1'b0, '0, '0, 1'b0, '0};
    case (m)
      MODE_INSERT: begin
        if (heap_cnt < HEAP_CAPACITY) begin
          heap_key[heap_cnt] = k;
          heap_hnd[heap_cnt] = h;
          pos = heap_cnt;
          heap_cnt++;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_key[up] > heap_key[pos]) begin
              heap_swap(up, pos);
              pos = up;
            end else begin
              break;
            end
          end
        end else begin
          r.ovf = 1'b1;
        end
      end
      MODE_POP: begin
        if (heap_cnt > 0) begin
          r.found = 1'b1;
          r.key   = heap_key[0];
          r.hnd   = heap_hnd[0];
          heap_cnt--;
          if (heap_cnt > 0) begin
            heap_key[0] = heap_key[heap_cnt];
            heap_hnd[0] = heap_hnd[heap_cnt];
            pos = 0;
            forever begin
              lt = 2 * pos + 1;
              if (lt >= heap_cnt) break;
              pick = lt;
              if (lt + 1 < heap_cnt && heap_key[lt+1] < heap_key[lt]) pick = lt + 1;
              if (heap_key[pick] < heap_key[pos]) begin
                heap_swap(pick, pos);
                pos = pick;
              end else begin
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (m != MODE_POP && heap_cnt > 0) begin
      r.found = 1'b1;
      r.key   = heap_key[0];
      r.hnd   = heap_hnd[0];
    end
    r.occ = OCC_BITS'(heap_cnt);
    return r;
  endfunction

  function automatic logic [KB-1:0] pick_key(bit narrow);
    if (narrow) return $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return MODE_INSERT;
    if (r < 80) return MODE_POP;
    if (r < 95) return MODE_PEEK;
    return MODE_SPARE;
  endfunction

  function automatic void add_row(logic [1:0] m, logic [KB-1:0] k, logic [HB-1:0] h, bit typed,
                                  logic fnd, logic [KB-1:0] okey, logic [HB-1:0] ohnd,
                                  logic ovf, int occ);
    req_row_t row;
    row.mode  = m;
    row.key   = k;
    row.hnd   = h;
    row.typed = typed;
    row.want  = '{fnd, okey, ohnd, ovf, occ[OCC_BITS-1:0]};
    req_tab   = {req_tab, row};
  endfunction

  function automatic void flag_err(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t ERROR %s", $time, msg);
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_beat(logic [1:0] m, logic [KB-1:0] k, logic [HB-1:0] h,
                           bit typed, heap_reply_t want);
    heap_reply_t pred;
    if (sent < ITEMS - CALM_TAIL && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    start    <= 1'b1;
    mode_i   <= m;
    key_i    <= k;
    handle_i <= h;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = heap_apply(m, k, h);
    heap_reply_q = {heap_reply_q, (typed ? want : pred)};
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_rand(logic [1:0] m, bit narrow);
    heap_reply_t none;
    none = '{1'b0, '0, '0, 1'b0, '0};
    send_beat(m, pick_key(narrow), HB'($urandom), 1'b0, none);
  endtask

  always @(posedge clk_i) begin
    heap_reply_t want;
    if (rst_ni && done_o) begin
      if (heap_reply_q.size() == 0) begin
        flag_err("result beat with nothing pending");
      end else begin
        want = heap_reply_q.pop_front();
        if (found_o !== want.found || out_key_o !== want.key || out_handle_o !== want.hnd ||
            overflow_o !== want.ovf || occupancy_o !== want.occ)
          flag_err($sformatf({"exp found=%0b key=%h hnd=%h ovf=%0b occ=%0d, ",
                              "got found=%0b key=%h hnd=%h ovf=%0b occ=%0d"},
                             want.found, want.key, want.hnd, want.ovf, want.occ,
                             found_o, out_key_o, out_handle_o, overflow_o, occupancy_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (start && !busy) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WDOG_LIMIT) begin
      $display("%0t watchdog: no request taken for %0d cycles", $time, WDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int phase;
    rst_ni   = 1'b0;
    start    = 1'b0;
    mode_i   = MODE_INSERT;
    key_i    = '0;
    handle_i = '0;

    // empty heap, extremes, equal keys, spare mode code
    add_row(MODE_PEEK,   '0,    '0,     1, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_POP,    '0,    '0,     1, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_SPARE,  '1,    '1,     1, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_INSERT, '1,    '1,     1, 1'b1, '1, '1, 1'b0, 1);
    add_row(MODE_INSERT, '0,    '0,     1, 1'b1, '0, '0, 1'b0, 2);
    add_row(MODE_INSERT, '1,    9'h0aa, 1, 1'b1, '0, '0, 1'b0, 3);
    add_row(MODE_INSERT, '0,    9'h155, 1, 1'b1, '0, '0, 1'b0, 4);
    add_row(MODE_PEEK,   '0,    '0,     1, 1'b1, '0, '0, 1'b0, 4);
    add_row(MODE_POP,    '0,    '0,     1, 1'b1, '0, '0, 1'b0, 3);
    add_row(MODE_POP,    '0,    '0,     0, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_INSERT, 32'd5, 9'd1,   0, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_INSERT, 32'd5, 9'd2,   0, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_INSERT, 32'd3, 9'd3,   0, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_INSERT, 32'd7, 9'd4,   0, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_INSERT, 32'd5, 9'd5,   0, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_SPARE,  '0,    '0,     0, 1'b0, '0, '0, 1'b0, 0);
    repeat (7) add_row(MODE_POP, '0, '0, 0, 1'b0, '0, '0, 1'b0, 0);
    add_row(MODE_POP,    '0,    '0,     1, 1'b0, '0, '0, 1'b0, 0);

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle_pct = 30;
    foreach (req_tab[i])
      send_beat(req_tab[i].mode, req_tab[i].key, req_tab[i].hnd, req_tab[i].typed,
                req_tab[i].want);

    phase = 0;
    while (sent < ITEMS) begin
      idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      case (phase % 4)
        0: begin
          while (heap_cnt < HEAP_CAPACITY && sent < ITEMS)
            send_rand(($urandom_range(0, 9) == 0) ? MODE_PEEK : MODE_INSERT, 1'b0);
          repeat ($urandom_range(1, 4)) send_rand(MODE_INSERT, 1'b0);
        end
        2: begin
          while (heap_cnt > 0 && sent < ITEMS)
            send_rand(($urandom_range(0, 9) == 0) ? MODE_PEEK : MODE_POP, 1'b0);
          repeat ($urandom_range(1, 3)) send_rand(pick_mode() == MODE_PEEK ? MODE_PEEK
                                                                             : MODE_POP, 1'b0);
        end
        default: begin
          repeat ($urandom_range(30, 80)) send_rand(pick_mode(), phase % 4 == 3);
        end
      endcase
      phase++;
    end
    start <= 1'b0;

    while (heap_reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bmhq_pkg.sv
rtl/core/bmhq_cell.sv
rtl/core/binary_min_heap_queue.sv
tb/sv/binary_min_heap_queue_tb.sv
